// ----- src/pcm_downmix_peak_decimator_unit_macros.svh -----
// Assertion macros shared by the peak decimator RTL.
`ifndef PCM_DOWNMIX_PEAK_DECIMATOR_UNIT_MACROS_SVH
`define PCM_DOWNMIX_PEAK_DECIMATOR_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PDPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PDPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- src/pdpd_pkg.sv -----
// Shared constants and types for the peak decimator.
`default_nettype none
package pdpd_pkg;
  localparam int unsigned DEF_MAX_BUCKETS  = 4096;
  localparam int unsigned DEF_MAX_CHANNELS = 8;
  localparam int unsigned DIV_W            = 48;

  localparam logic [2:0] REG_FLOAT    = 3'd0;
  localparam logic [2:0] REG_BYTES    = 3'd1;
  localparam logic [2:0] REG_CHANNELS = 3'd2;
  localparam logic [2:0] REG_FRAMES   = 3'd3;
  localparam logic [2:0] REG_BUCKETS  = 3'd4;

  // Request and status between the sequencer and the divider.
  typedef struct packed {
    logic              start;
    logic              negate;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_sts_t;
endpackage
`default_nettype wire

// ----- src/pdpd_divider.sv -----
// Radix-2 restoring divider for magnitudes, one quotient bit per cycle.
`default_nettype none
`include "pcm_downmix_peak_decimator_unit_macros.svh"
module pdpd_divider (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pdpd_pkg::div_req_t req,
  output pdpd_pkg::div_sts_t    sts
);
  localparam int unsigned W  = pdpd_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [W:0]    trial;

  // One shift-subtract step per cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};
    if (req.start && !busy_r) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      neg_nxt  = req.negate;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (neg_r) begin
          quo_nxt = -quo_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

  `PDPD_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_r, !busy_r, "divider done while busy")
  `PDPD_ASSERT_NXT(a_start_busy, clk, rst_n, req.start && !busy_r, busy_r, "divider did not start")
  `PDPD_ASSERT_IMP(a_cnt_idle, clk, rst_n, !busy_r, cnt_r == '0, "divider count left over")
endmodule
`default_nettype wire

// ----- src/pcm_downmix_peak_decimator_unit.sv -----
// Usage: one channel sample word per item on the in_ channel (in_valid, in_stall out).
// Samples are decoded to Q1.31 and summed; on a frame's last channel the sum is
// divided by the channel count to give the mono value, and min/max are tracked.
// When a bucket closes one item leaves on the out_ channel (out_valid, out_stall in).
// A sample that does not end a frame leaves the block ready for the next sample.
// A frame-ending sample stalls the input for the mono division, and one that closes
// a bucket also for the division that finds the next bucket's end frame.
// Both divisions use one shared 48-step divider.
// A result waits in the output register; the block takes a new item meanwhile but
// will not close another bucket until that result has been taken.
// Configuration writes via cfg_ to indices 0 to 4 recompute the current bucket end.
// Reset: synchronous, active low. After reset the end of bucket zero is computed
// by the divider, so in_stall stays high until that division is done.
// Items beyond frame_count, and float items with sample_bytes below 4 (values above 4
// count as 4), are consumed with no effect.
`default_nettype none
`include "pcm_downmix_peak_decimator_unit_macros.svh"
module pcm_downmix_peak_decimator_unit #(
  parameter int unsigned MAX_BUCKETS  = pdpd_pkg::DEF_MAX_BUCKETS,
  parameter int unsigned MAX_CHANNELS = pdpd_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [31:0]  in_sample_word,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [11:0]       out_bucket_index,
  output logic signed [31:0] out_peak_min,
  output logic signed [31:0] out_peak_max,
  output logic              out_final_bucket,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  localparam int unsigned W   = pdpd_pkg::DIV_W;
  localparam int unsigned CPW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned SW  = 32 + $clog2(MAX_CHANNELS);

  typedef enum logic [2:0] {
    ST_END_START, ST_END_WAIT, ST_IDLE, ST_MONO_WAIT, ST_OUT_WAIT
  } state_t;

  state_t state_r;
  logic        float_r;
  logic [2:0]  bytes_r;
  logic [3:0]  chan_r;
  logic [31:0] frames_r;
  logic [12:0] buckets_r;
  logic [CPW-1:0] chpos_r;
  logic signed [SW-1:0] sum_r;
  logic [31:0] fpos_r;
  logic [11:0] cur_r;
  logic [31:0] end_r;
  logic signed [31:0] min_r, max_r, mono_r;
  logic        started_r;
  logic        start_r, neg_r;
  logic [W-1:0] dvd_r, dvs_r;

  // Effective configuration.
  logic [2:0]  eff_bytes;
  logic [6:0]  eff_ch;
  logic [31:0] eff_bk;
  logic [16:0] bk_cl;
  always_comb begin
    eff_bytes = (bytes_r == 3'd0) ? 3'd1 : ((bytes_r > 3'd4) ? 3'd4 : bytes_r);
    eff_ch = (chan_r == 4'd0) ? 7'd1 :
             ((32'(chan_r) > MAX_CHANNELS) ? 7'(MAX_CHANNELS) : 7'(chan_r));
    bk_cl = (buckets_r == 13'd0) ? 17'd1 :
            ((32'(buckets_r) > MAX_BUCKETS) ? 17'(MAX_BUCKETS) : 17'(buckets_r));
    eff_bk = (32'(bk_cl) > frames_r) ? frames_r : 32'(bk_cl);
  end

  // Sample decode to Q1.31.
  logic signed [31:0] dec;
  logic [7:0]  fex;
  logic [23:0] fman;
  logic [40:0] fmag;
  logic [31:0] fsat;
  always_comb begin
    fex  = in_sample_word[30:23];
    fman = {fex != 8'd0, in_sample_word[22:0]};
    fmag = '0;
    if (fex == 8'hFF) begin
      fmag = (in_sample_word[22:0] != '0) ? 41'd0 : 41'h100_0000_0000;
    end else if (fex == 8'd0) begin
      fmag = '0;
    end else if (fex >= 8'd119) begin
      fmag = (fex > 8'd135) ? 41'h100_0000_0000 : (41'(fman) << (fex - 8'd119));
    end else begin
      fmag = 41'(fman) >> (8'd119 - fex);
    end
    if (in_sample_word[31]) begin
      fsat = (fmag > 41'h80000000) ? 32'h80000000 : -fmag[31:0];
    end else begin
      fsat = (fmag > 41'h7FFFFFFF) ? 32'h7FFFFFFF : fmag[31:0];
    end
    if (float_r) begin
      dec = fsat;
    end else begin
      case (eff_bytes)
        3'd1:    dec = {in_sample_word[7:0] ^ 8'h80, 24'd0};
        3'd2:    dec = {in_sample_word[15:0], 16'd0};
        3'd3:    dec = {in_sample_word[23:0], 8'd0};
        default: dec = in_sample_word;
      endcase
    end
  end

  pdpd_pkg::div_req_t req;
  pdpd_pkg::div_sts_t sts;
  assign req.start    = start_r;
  assign req.negate   = neg_r;
  assign req.dividend = dvd_r;
  assign req.divisor  = dvs_r;

  pdpd_divider u_div (.clk(clk), .rst_n(rst_n), .req(req), .sts(sts));

  logic in_acc, out_acc, ignore, frame_done;
  logic signed [SW-1:0] sum_new;
  logic [31:0] fpos_inc;
  logic [44:0] end_num;
  logic signed [31:0] mono_q, nmin, nmax;
  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;
  assign ignore     = (frames_r == '0) || (fpos_r >= frames_r) || (float_r && eff_bytes != 3'd4);
  assign sum_new    = sum_r + SW'(dec);
  assign frame_done = (7'(chpos_r) + 7'd1) >= eff_ch;
  assign in_stall   = (state_r != ST_IDLE) || cfg_we;
  assign fpos_inc   = fpos_r + 32'd1;
  assign end_num    = 45'({1'b0, cur_r} + 13'd1) * 45'(frames_r);
  assign mono_q     = sts.quotient[31:0];
  assign nmin       = (!started_r || mono_r < min_r) ? mono_r : min_r;
  assign nmax       = (!started_r || mono_r > max_r) ? mono_r : max_r;

  // Sequencer, configuration and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_END_START;
      float_r   <= 1'b0;
      bytes_r   <= 3'd2;
      chan_r    <= 4'd1;
      frames_r  <= 32'd1;
      buckets_r <= 13'd4096;
      chpos_r   <= '0;
      sum_r     <= '0;
      fpos_r    <= '0;
      cur_r     <= '0;
      end_r     <= '0;
      started_r <= 1'b0;
      start_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_acc) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          pdpd_pkg::REG_FLOAT:    float_r   <= cfg_data[0];
          pdpd_pkg::REG_BYTES:    bytes_r   <= cfg_data[2:0];
          pdpd_pkg::REG_CHANNELS: chan_r    <= cfg_data[3:0];
          pdpd_pkg::REG_FRAMES:   frames_r  <= cfg_data;
          pdpd_pkg::REG_BUCKETS:  buckets_r <= cfg_data[12:0];
          default: ;
        endcase
        if (cfg_index <= pdpd_pkg::REG_BUCKETS) begin
          state_r <= ST_END_START;
        end
      end else begin
        case (state_r)
          ST_END_START: begin
            if (!sts.busy) begin
              dvd_r   <= W'(end_num);
              dvs_r   <= W'(eff_bk);
              neg_r   <= 1'b0;
              start_r <= 1'b1;
              state_r <= ST_END_WAIT;
            end
          end
          ST_END_WAIT: begin
            if (sts.done) begin
              end_r   <= (eff_bk == '0) ? 32'd0 : sts.quotient[31:0];
              state_r <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_acc && !ignore) begin
              if (frame_done) begin
                dvd_r   <= W'(sum_new[SW-1] ? -sum_new : sum_new);
                dvs_r   <= W'(eff_ch);
                neg_r   <= sum_new[SW-1];
                start_r <= 1'b1;
                sum_r   <= '0;
                chpos_r <= '0;
                state_r <= ST_MONO_WAIT;
              end else begin
                sum_r   <= sum_new;
                chpos_r <= chpos_r + CPW'(1);
              end
            end
          end
          ST_MONO_WAIT: begin
            if (sts.done) begin
              mono_r  <= mono_q;
              state_r <= ST_OUT_WAIT;
            end
          end
          ST_OUT_WAIT: begin
            if (fpos_inc < end_r && fpos_inc < frames_r) begin
              min_r     <= nmin;
              max_r     <= nmax;
              started_r <= 1'b1;
              fpos_r    <= fpos_inc;
              state_r   <= ST_IDLE;
            end else if (!out_valid || out_acc) begin
              out_valid        <= 1'b1;
              out_bucket_index <= cur_r;
              out_peak_min     <= nmin;
              out_peak_max     <= nmax;
              out_final_bucket <= fpos_inc >= frames_r;
              started_r        <= 1'b0;
              fpos_r           <= fpos_inc;
              cur_r            <= cur_r + 12'd1;
              state_r          <= ST_END_START;
            end
          end
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

  `PDPD_ASSERT_IMP(a_stall_busy, clk, rst_n, state_r != ST_IDLE, in_stall, "item taken while busy")
  `PDPD_ASSERT_IMP(a_min_le_max, clk, rst_n, out_valid, out_peak_min <= out_peak_max, "min above max")
  `PDPD_ASSERT_IMP(a_chpos, clk, rst_n, state_r == ST_MONO_WAIT, chpos_r == '0, "channel count kept")
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the PCM downmix peak decimator unit.
`timescale 1ns / 100ps

// One bucket's peak pair as it should appear on the result channel.
typedef struct {
  logic [11:0]        bucket_index;
  logic signed [31:0] peak_min;
  logic signed [31:0] peak_max;
  logic               final_bucket;
} bucket_peak_t;

// Tracks the decimator's state and the queue of bucket peaks still owed.
class peak_scoreboard;
  logic              float_mode;
  logic [2:0]        word_bytes;
  logic [3:0]        channels;
  logic [31:0]       total_frames;
  logic [12:0]       buckets_req;
  int unsigned       chan_pos;
  longint            chan_sum;
  longint unsigned   frame_pos;
  logic [11:0]       bucket;
  longint unsigned   end_frame;
  longint            run_min;
  longint            run_max;
  bit                started;
  bucket_peak_t      pending_peaks[$];
  int                errors;

  function void clear();
    float_mode = 1'b0;
    word_bytes = 3'd2;
    channels = 4'd1;
    total_frames = 32'd1;
    buckets_req = 13'd4096;
    chan_pos = 0;
    chan_sum = 0;
    frame_pos = 0;
    bucket = '0;
    run_min = 0;
    run_max = 0;
    started = 1'b0;
    errors = 0;
    find_bucket_end();
  endfunction

  function int unsigned bytes_used();
    if (word_bytes < 1) return 1;
    if (word_bytes > 4) return 4;
    return word_bytes;
  endfunction

  function int unsigned chans_used();
    if (channels < 1) return 1;
    if (channels > 8) return 8;
    return channels;
  endfunction

  // Bucket i ends before frame floor((i+1)*N/B), with B clamped to 1..4096, then to N.
  function void find_bucket_end();
    longint unsigned b;
    b = buckets_req;
    if (b < 1) b = 1;
    if (b > 4096) b = 4096;
    if (b > total_frames) b = total_frames;
    if (b == 0) end_frame = 0;
    else end_frame = ((longint'(bucket) + 1) * total_frames / b) & 64'hFFFF_FFFF;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      pdpd_pkg::REG_FLOAT:    float_mode = val[0];
      pdpd_pkg::REG_BYTES:    word_bytes = val[2:0];
      pdpd_pkg::REG_CHANNELS: channels = val[3:0];
      pdpd_pkg::REG_FRAMES:   total_frames = val;
      pdpd_pkg::REG_BUCKETS:  buckets_req = val[12:0];
      default: return;
    endcase
    find_bucket_end();
  endfunction

  // IEEE single to Q1.31: scale by 2^31, truncate, saturate; NaN reads as zero.
  function longint float_to_fixed(logic [31:0] w);
    longint unsigned mant, mag;
    int shift;
    mant = w[22:0];
    if (w[30:23] == 8'hFF) begin
      if (mant != 0) return 0;
      mag = 64'd1 << 40;
    end else begin
      if (w[30:23] == 0) begin
        shift = -118;
      end else begin
        mant |= 64'd1 << 23;
        shift = int'(w[30:23]) - 119;
      end
      if (shift >= 0) mag = (shift > 16) ? (64'd1 << 40) : (mant << shift);
      else mag = (-shift >= 63) ? 0 : (mant >> (-shift));
    end
    if (w[31]) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return -longint'(mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return longint'(mag);
  endfunction

  function longint sample_to_fixed(logic [31:0] w);
    if (float_mode) return float_to_fixed(w);
    case (bytes_used())
      1: return (longint'(w[7:0]) - 128) * 64'sd16777216;
      2: return longint'($signed(w[15:0])) * 64'sd65536;
      3: return longint'($signed(w[23:0])) * 64'sd256;
      default: return longint'($signed(w));
    endcase
  endfunction

  // Called for every sample the block accepts.
  function void note_input(logic [31:0] w);
    longint mono;
    bit last;
    bucket_peak_t p;
    if (total_frames == 0 || frame_pos >= total_frames) return;
    if (float_mode && bytes_used() != 4) return;
    chan_sum += sample_to_fixed(w);
    if (chan_pos + 1 < chans_used()) begin
      chan_pos++;
      return;
    end
    mono = chan_sum / longint'(chans_used());
    chan_sum = 0;
    chan_pos = 0;
    if (!started) begin
      run_min = mono;
      run_max = mono;
      started = 1'b1;
    end else begin
      if (mono < run_min) run_min = mono;
      if (mono > run_max) run_max = mono;
    end
    frame_pos++;
    last = frame_pos >= total_frames;
    if (frame_pos < end_frame && !last) return;
    p.bucket_index = bucket;
    p.peak_min = run_min[31:0];
    p.peak_max = run_max[31:0];
    p.final_bucket = last;
    pending_peaks.push_back(p);
    bucket = bucket + 1'b1;
    started = 1'b0;
    find_bucket_end();
  endfunction

  // Called for every result the block hands over.
  function void check_peak(bucket_peak_t got);
    bucket_peak_t exp_p;
    if (pending_peaks.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: bucket %0d min %0d max %0d final %0b",
                 got.bucket_index, got.peak_min, got.peak_max, got.final_bucket);
      return;
    end
    exp_p = pending_peaks.pop_front();
    if (got.bucket_index !== exp_p.bucket_index || got.peak_min !== exp_p.peak_min ||
        got.peak_max !== exp_p.peak_max || got.final_bucket !== exp_p.final_bucket) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected bucket %0d min %0d max %0d final %0b, got %0d %0d %0d %0b",
                 exp_p.bucket_index, exp_p.peak_min, exp_p.peak_max, exp_p.final_bucket,
                 got.bucket_index, got.peak_min, got.peak_max, got.final_bucket);
    end
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        in_sample_word;
  logic               out_valid;
  logic               out_stall;
  logic [11:0]        out_bucket_index;
  logic signed [31:0] out_peak_min;
  logic signed [31:0] out_peak_max;
  logic               out_final_bucket;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  peak_scoreboard sb;
  int send_gap_pct;
  int recv_stall_pct;
  int quiet_cycles = 0;
  int random_items;

  pcm_downmix_peak_decimator_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_word(in_sample_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bucket_index(out_bucket_index), .out_peak_min(out_peak_min),
    .out_peak_max(out_peak_max), .out_final_bucket(out_final_bucket),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check each result the moment it is taken.
  always @(posedge clk) begin
    bucket_peak_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.bucket_index = out_bucket_index;
      got.peak_min = out_peak_min;
      got.peak_max = out_peak_max;
      got.final_bucket = out_final_bucket;
      sb.check_peak(got);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one sample, with a random gap before it, and wait for it to be taken.
  task automatic send_sample(input logic [31:0] w);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  // Let every owed result arrive, then give the block time to go idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_peaks.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // A register write; the bucket end is recomputed afterward, so wait that out.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    repeat (64) @(posedge clk);
  endtask

  task automatic set_format(input logic fl, input logic [2:0] nb, input logic [3:0] nch);
    write_reg(pdpd_pkg::REG_FLOAT, 32'(fl));
    write_reg(pdpd_pkg::REG_BYTES, 32'(nb));
    write_reg(pdpd_pkg::REG_CHANNELS, 32'(nch));
  endtask

  task automatic set_track(input logic [31:0] frames, input logic [12:0] nbuck);
    write_reg(pdpd_pkg::REG_FRAMES, frames);
    write_reg(pdpd_pkg::REG_BUCKETS, 32'(nbuck));
  endtask

  // Random float near full scale, with the odd special value.
  function automatic logic [31:0] random_float();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 1))};
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 135)),
                       23'($urandom)};
    endcase
  endfunction

  initial begin
    logic        fl;
    logic [2:0]  nb;
    logic [3:0]  nch;
    logic [31:0] frames;
    logic [12:0] nbuck;
    int          phase;
    int          count;

    sb = new();
    sb.clear();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample_word <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    random_items = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one 16-bit frame, then items past the end are dropped.
    send_sample(32'h0000_8000);
    send_sample(32'h0000_7FFF);
    drain();

    // 8-bit unsigned extremes; the upper bytes must be ignored.
    set_format(1'b0, 3'd1, 4'd1);
    set_track(32'(sb.frame_pos + 4), 13'd2);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0080);
    send_sample(32'h1234_567F);
    drain();

    // 24-bit stereo: the two range limits, then minus one with zero.
    set_format(1'b0, 3'd3, 4'd2);
    set_track(32'(sb.frame_pos + 2), 13'd0);
    send_sample(32'h0080_0000);
    send_sample(32'hFF7F_FFFF);
    send_sample(32'h00FF_FFFF);
    send_sample(32'h0000_0000);
    drain();

    // 32-bit, three channels, two of them at the negative limit.
    set_format(1'b0, 3'd4, 4'd3);
    set_track(32'(sb.frame_pos + 1), 13'd8191);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0001);
    drain();

    // Float: infinities, NaN, unity saturation, denormal, one half.
    set_format(1'b1, 3'd4, 4'd1);
    set_track(32'(sb.frame_pos + 7), 13'd4096);
    send_sample(32'h7F80_0000);
    send_sample(32'hFF80_0000);
    send_sample(32'h7FC0_0001);
    send_sample(32'h3F80_0000);
    send_sample(32'hBF80_0000);
    send_sample(32'h0000_0001);
    send_sample(32'h3F00_0000);
    drain();

    // Float with a width other than four bytes is dropped.
    write_reg(pdpd_pkg::REG_BYTES, 32'd2);
    write_reg(pdpd_pkg::REG_FRAMES, 32'(sb.frame_pos + 3));
    send_sample(32'h3F80_0000);
    send_sample(32'hDEAD_BEEF);
    drain();

    // Zero frame count drops everything; then the largest frame count.
    set_format(1'b0, 3'd0, 4'd0);
    write_reg(pdpd_pkg::REG_FRAMES, 32'd0);
    send_sample(32'h0000_00FF);
    drain();
    set_format(1'b0, 3'd7, 4'd15);
    set_track(32'hFFFF_FFFF, 13'd1);
    repeat (4) send_sample($urandom);
    drain();

    // Random phases cycling through the idling modes.
    phase = 0;
    while (random_items < 750) begin
      case (phase % 5)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 82; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 82; end
        3: begin send_gap_pct = 29; recv_stall_pct = 29; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      fl = ($urandom_range(0, 3) == 0);
      nb = fl ? (($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd4) : 3'($urandom);
      nch = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
      frames = 32'(sb.frame_pos + $urandom_range(1, 30));
      case ($urandom_range(0, 4))
        0: nbuck = 13'd1;
        1: nbuck = 13'd4096;
        2: nbuck = 13'($urandom);
        default: nbuck = 13'($urandom_range(2, 12));
      endcase
      set_format(fl, nb, nch);
      set_track(frames, nbuck);
      count = int'((64'(frames) - sb.frame_pos) * sb.chans_used())
              + int'($urandom_range(0, 3));
      for (int i = 0; i < count; i++) begin
        if (phase % 5 == 4 && i == count / 2) begin
          // Hold the sender off until every owed result is out.
          in_valid <= 1'b0;
          while (sb.pending_peaks.size() != 0) @(posedge clk);
        end
        if (fl) send_sample(random_float());
        else if ($urandom_range(0, 7) == 0) send_sample($urandom_range(0, 1) ? 32'h8000_0000
                                                                              : 32'h7FFF_FFFF);
        else send_sample($urandom);
        random_items++;
      end
      drain();
      phase++;
    end

    drain();
    if (sb.errors == 0 && sb.pending_peaks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/pdpd_pkg.sv
src/pdpd_divider.sv
src/pcm_downmix_peak_decimator_unit.sv
sim/testbench.sv
